// ----- hdl/block_bitmap_next_fit_allocator_macros.svh -----
// Assertion macros shared by the allocator modules.
// Defining NO_ASSERTIONS turns every use into empty text.
`ifndef BLOCK_BITMAP_NEXT_FIT_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_NEXT_FIT_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property checked at every rising edge outside reset.
`define BBNF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// An implication checked at every rising edge outside reset.
`define BBNF_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define BBNF_ASSERT(lbl, clk, rst, prop, msg)
`define BBNF_ASSERT_IMP(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ----- hdl/bbnf_pkg.sv -----
package bbnf_pkg;

  // Field widths fixed by the interface.
  localparam int CNT_W    = 13;
  localparam int BLK_W    = 12;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int CNT_RESET = 4096;

  localparam int DEF_MAX_BLOCKS = 4096;
  localparam int DEF_WORD_BITS  = 32;

  // Fixed-point shift used for the divide-by-word-size reciprocal.
  localparam int DIV_SHIFT = 16;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic div_step;
    logic split;
    logic astart;
    logic scan;
    logic alloc_wr;
    logic mod;
    logic res_nospace;
    logic res_oor;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic cnt_zero;
    logic oor;
    logic chk_vld;
    logic hit;
    logic wrapped;
    logic out_free;
  } sts_t;

  function automatic int addr_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- hdl/bbnf_ram.sv -----
module bbnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = bbnf_pkg::addr_width(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bbnf_dp.sv -----
`include "block_bitmap_next_fit_allocator_macros.svh"

module bbnf_dp #(
  parameter int MAX_BLOCKS = bbnf_pkg::DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = bbnf_pkg::DEF_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bbnf_pkg::CNT_W-1:0]    cfg_data,
  input  logic [bbnf_pkg::MODE_W-1:0]   mode,
  input  logic [bbnf_pkg::BLK_W-1:0]    block,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bbnf_pkg::STATUS_W-1:0] status,
  output logic [bbnf_pkg::BLK_W-1:0]    block_out,
  output logic                          in_use,
  input  bbnf_pkg::cmd_t                cmd,
  output bbnf_pkg::sts_t                sts
);
  import bbnf_pkg::*;

  localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = addr_width(WORD_COUNT);
  localparam int BW         = $clog2(WORD_BITS);
  localparam int BASE_W     = CNT_W + 1;
  localparam int MAXC       = (MAX_BLOCKS > CNT_MAX) ? CNT_MAX : MAX_BLOCKS;
  localparam int RW         = DIV_SHIFT + 1;
  localparam int DIV_RECIP  = (1 << DIV_SHIFT) / WORD_BITS;
  localparam int PW         = BLK_W + RW;
  localparam int QW         = BLK_W + BW + 1;
  localparam int LIN_W      = AW + BW + 2;
  localparam int CMP_W      = (LIN_W > BASE_W) ? LIN_W : BASE_W;

  // Configuration and request registers.
  logic [CNT_W-1:0]     block_count;
  logic [MODE_W-1:0]    op_mode;
  logic [BLK_W-1:0]     op_blk;
  logic [BLK_W-1:0]     q_est;
  logic [AW-1:0]        op_w;
  logic [BW-1:0]        op_b;

  // Next-fit position, kept as word and bit.
  logic [AW-1:0]        sp_w;
  logic [BW-1:0]        sp_b;

  // Scan pointers: issue side addresses the RAM, check side sees its data.
  logic [AW-1:0]        start_w;
  logic [AW-1:0]        iss_w;
  logic [BASE_W-1:0]    iss_base;
  logic [AW-1:0]        chk_w;
  logic [BASE_W-1:0]    chk_base;
  logic                 chk_vld;

  logic [AW-1:0]        hit_w;
  logic [BW-1:0]        hit_b;
  logic [CNT_W-1:0]     found;
  logic [WORD_BITS-1:0] hit_word;

  logic [STATUS_W-1:0]  res_status;
  logic [BLK_W-1:0]     res_block;
  logic                 res_used;

  logic [AW-1:0]        clr_addr;

  // RAM ports.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] rdata;

  logic [CNT_W-1:0]     count_eff;
  logic [PW-1:0]        qprod;
  logic [QW-1:0]        qw_prod;
  logic [BLK_W-1:0]     rem;
  logic                 rem_hi;
  logic [BLK_W-1:0]     q_fix;
  logic [BLK_W-1:0]     r_fix;

  logic [BW:0]          sp_b1;
  logic                 b_wrap;
  logic [AW:0]          nw;
  logic [BW-1:0]        nb;
  logic [CMP_W-1:0]     nw_base;
  logic [CMP_W-1:0]     start_lin;
  logic                 start_ok;

  logic [BASE_W-1:0]    iss_nbase;
  logic                 iss_wrap;
  logic [BASE_W-1:0]    chk_nbase;
  logic                 chk_wrap;
  logic [AW-1:0]        chk_next_w;

  logic [BASE_W-1:0]    lim;
  logic [WORD_BITS-1:0] free_bits;
  logic [BW-1:0]        hit_bit_c;
  logic                 hit_c;

  logic [WORD_BITS-1:0] op_mask;
  logic [WORD_BITS-1:0] new_word;

  assign count_eff = (block_count > CNT_W'(MAXC)) ? CNT_W'(MAXC) : block_count;

  // Quotient estimate by reciprocal; at most one short, fixed in split.
  assign qprod   = PW'(op_blk) * PW'(DIV_RECIP);
  assign qw_prod = QW'(q_est) * QW'(WORD_BITS);
  assign rem     = op_blk - qw_prod[BLK_W-1:0];
  assign rem_hi  = rem >= BLK_W'(WORD_BITS);
  assign q_fix   = rem_hi ? q_est + 1'b1 : q_est;
  assign r_fix   = rem_hi ? rem - BLK_W'(WORD_BITS) : rem;

  // Start of the search is the block after the last one handed out.
  assign sp_b1     = {1'b0, sp_b} + 1'b1;
  assign b_wrap    = sp_b1 == (BW + 1)'(WORD_BITS);
  assign nw        = b_wrap ? {1'b0, sp_w} + 1'b1 : {1'b0, sp_w};
  assign nb        = b_wrap ? '0 : sp_b1[BW-1:0];
  assign nw_base   = CMP_W'(nw) * CMP_W'(WORD_BITS);
  assign start_lin = nw_base + CMP_W'(nb);
  assign start_ok  = start_lin < CMP_W'(count_eff);

  assign iss_nbase  = iss_base + BASE_W'(WORD_BITS);
  assign iss_wrap   = iss_nbase >= BASE_W'(count_eff);
  assign chk_nbase  = chk_base + BASE_W'(WORD_BITS);
  assign chk_wrap   = chk_nbase >= BASE_W'(count_eff);
  assign chk_next_w = chk_wrap ? '0 : chk_w + 1'b1;

  // Clear bits of the checked word that lie below the block count.
  assign lim = BASE_W'(count_eff) - chk_base;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      free_bits[i] = !rdata[i] && (BASE_W'(i) < lim);
    end
  end

  always_comb begin
    hit_bit_c = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_bit_c = BW'(i);
      end
    end
  end

  assign hit_c = |free_bits;

  assign op_mask = WORD_BITS'(1) << op_b;

  always_comb begin
    case (op_mode)
      MODE_FREE: new_word = rdata & ~op_mask;
      MODE_MARK: new_word = rdata | op_mask;
      default:   new_word = rdata;
    endcase
  end

  always_comb begin
    ram_we    = cmd.clr_wr || cmd.mod || cmd.alloc_wr;
    ram_waddr = hit_w;
    ram_wdata = hit_word;
    if (cmd.clr_wr) begin
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (cmd.mod) begin
      ram_waddr = op_w;
      ram_wdata = new_word;
    end
    ram_raddr = cmd.scan ? iss_w : op_w;
  end

  bbnf_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORD_COUNT)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_comb begin
    sts.clr_last = clr_addr == AW'(WORD_COUNT - 1);
    sts.is_alloc = op_mode == MODE_ALLOC;
    sts.cnt_zero = count_eff == '0;
    sts.oor      = CNT_W'(op_blk) >= count_eff;
    sts.chk_vld  = chk_vld;
    sts.hit      = hit_c;
    sts.wrapped  = chk_next_w == start_w;
    sts.out_free = !out_valid || !out_stall;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= CNT_W'(CNT_RESET);
      clr_addr    <= '0;
      sp_w        <= '0;
      sp_b        <= '0;
      chk_vld     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_data;
      end
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.alloc_wr) begin
        sp_w <= hit_w;
        sp_b <= hit_b;
      end
      if (cmd.astart) begin
        chk_vld <= 1'b0;
      end else if (cmd.scan) begin
        chk_vld <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_mode <= mode;
      op_blk  <= block;
    end
    if (cmd.div_step) begin
      q_est <= qprod[DIV_SHIFT +: BLK_W];
    end
    if (cmd.split) begin
      op_w <= AW'(q_fix);
      op_b <= BW'(r_fix);
    end
    if (cmd.astart) begin
      start_w  <= start_ok ? AW'(nw) : '0;
      iss_w    <= start_ok ? AW'(nw) : '0;
      iss_base <= start_ok ? BASE_W'(nw_base) : '0;
    end
    if (cmd.scan) begin
      iss_w    <= iss_wrap ? '0 : iss_w + 1'b1;
      iss_base <= iss_wrap ? '0 : iss_nbase;
      chk_w    <= iss_w;
      chk_base <= iss_base;
      if (chk_vld && hit_c) begin
        hit_w    <= chk_w;
        hit_b    <= hit_bit_c;
        found    <= CNT_W'(chk_base + BASE_W'(hit_bit_c));
        hit_word <= rdata | (WORD_BITS'(1) << hit_bit_c);
      end
    end
    if (cmd.mod) begin
      res_status <= ST_OK;
      res_block  <= op_blk;
      res_used   <= new_word[op_b];
    end else if (cmd.alloc_wr) begin
      res_status <= ST_OK;
      res_block  <= found[BLK_W-1:0];
      res_used   <= 1'b1;
    end else if (cmd.res_nospace) begin
      res_status <= ST_NOSPACE;
      res_block  <= '0;
      res_used   <= 1'b0;
    end else if (cmd.res_oor) begin
      res_status <= ST_RANGE;
      res_block  <= op_blk;
      res_used   <= 1'b0;
    end
    if (cmd.load_out) begin
      status    <= res_status;
      block_out <= res_block;
      in_use    <= res_used;
    end
  end

  `BBNF_ASSERT_IMP(a_alloc_in_range, clk, rst, cmd.alloc_wr, found < count_eff, "allocated block is not below the block count")
  `BBNF_ASSERT_IMP(a_mod_in_range, clk, rst, cmd.mod, !sts.oor, "bitmap update for a block out of range")

endmodule

// ----- hdl/bbnf_ctrl.sv -----
`include "block_bitmap_next_fit_allocator_macros.svh"

module bbnf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bbnf_pkg::sts_t sts,
  output bbnf_pkg::cmd_t cmd
);
  import bbnf_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_MOD   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_AWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_alloc) begin
          if (sts.cnt_zero) begin
            cmd.res_nospace = 1'b1;
            state_next      = S_DONE;
          end else begin
            cmd.astart = 1'b1;
            state_next = S_SCAN;
          end
        end else if (sts.oor) begin
          cmd.res_oor = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
          state_next   = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.mod    = 1'b1;
        state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.chk_vld && sts.hit) begin
          state_next = S_AWR;
        end else if (sts.chk_vld && sts.wrapped) begin
          cmd.res_nospace = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_AWR: begin
        cmd.alloc_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  `BBNF_ASSERT_IMP(a_load_when_free, clk, rst, cmd.load_out, sts.out_free, "result loaded over one not yet taken")
  `BBNF_ASSERT(a_hit_goes_write, clk, rst, (state == S_SCAN && sts.chk_vld && sts.hit) |=> (state == S_AWR), "scan hit did not lead to the bitmap write")
  `BBNF_ASSERT(a_accept_checks, clk, rst, (in_valid && !in_stall) |=> (state == S_CHECK), "accepted request did not enter the check state")

endmodule

// ----- hdl/block_bitmap_next_fit_allocator.sv -----
// Free, mark and test go through the check, split, read, modify and done states once the
// request is taken; an out-of-range block or a zero block count goes from check to done.
// Allocate checks at most 128 bitmap words, then writes back the hit if a block is free.
// Requests are taken one at a time, at the earliest in the cycle after the previous
// result is loaded.
// Reset is synchronous; a clearing pass then writes every bitmap word to zero.
module block_bitmap_next_fit_allocator #(
  parameter int MAX_BLOCKS = bbnf_pkg::DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = bbnf_pkg::DEF_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Block count register.
  input  logic                          cfg_we,
  input  logic [bbnf_pkg::CNT_W-1:0]    cfg_data,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bbnf_pkg::MODE_W-1:0]   mode,
  input  logic [bbnf_pkg::BLK_W-1:0]    block,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bbnf_pkg::STATUS_W-1:0] status,
  output logic [bbnf_pkg::BLK_W-1:0]    block_out,
  output logic                          in_use
);
  import bbnf_pkg::*;

  // The controller sequences each request; the datapath holds the bitmap RAM,
  // the next-fit position, the scan pointers and the result registers.
  cmd_t cmd;
  sts_t sts;

  // The controller walks one request at a time. Allocate reads the bitmap
  // words circularly starting at the word that holds the block after the last
  // allocation. Reads are pipelined: a new word address is issued every cycle
  // while the word read in the previous cycle is checked for a clear bit below
  // the block count. The first hit is written back with its bit set and becomes
  // the new search position. Free, mark and test first split the block number
  // into word and bit (a reciprocal multiply, then one correction step), then
  // do a read-modify-write of that one word.
  bbnf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The result register decouples the two sides: a finished result may wait
  // for the consumer while the next request is already taken and worked on.
  bbnf_dp #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .mode     (mode),
    .block    (block),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .block_out(block_out),
    .in_use   (in_use),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
